/* rtl/core/camsf_pkg.sv */
// ----------------------------------------------------------------------------
// camsf_pkg
// Shared types and constants for the smooth-follow camera block.
// ----------------------------------------------------------------------------
package camsf_pkg;

  localparam int ROOT_STEPS = 33;
  localparam int DIV_STEPS  = 44;
  localparam int CNT_W      = 6;

  localparam logic [1:0] CFG_MIN_EFFECT_LENGTH = 2'd0;
  localparam logic [1:0] CFG_FRACTION_GAIN     = 2'd1;
  localparam logic [1:0] CFG_MIN_SPEED         = 2'd2;

  localparam logic [23:0] RST_MIN_EFFECT_LENGTH = 24'd2560;
  localparam logic [15:0] RST_FRACTION_GAIN     = 16'd205;
  localparam logic [23:0] RST_MIN_SPEED         = 24'd7680;

  localparam logic [33:0] STEP_MAX = 34'h2_0000_0000;

  typedef struct packed {
    logic load;
    logic diff;
    logic absval;
    logic square;
    logic sum;
    logic root_step;
    logic compare;
    logic speed_mul;
    logic speed_max;
    logic factor;
    logic mul_lo;
    logic mul_hi;
    logic num;
    logic div_step;
    logic update;
    logic axis;
    logic out_load;
  } camsf_cmd_t;

  typedef struct packed {
    logic above;
    logic out_free;
  } camsf_status_t;

endpackage

/* rtl/core/camsf_datapath.sv */
// ----------------------------------------------------------------------------
// camsf_datapath
// Distance, speed and step arithmetic with the camera target and config regs.
// ----------------------------------------------------------------------------
module camsf_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  camsf_pkg::camsf_cmd_t  cmd,
  output camsf_pkg::camsf_status_t status,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [23:0]            cfg_data,
  input  logic signed [31:0]     pos_x,
  input  logic signed [31:0]     pos_y,
  input  logic [15:0]            frame_time,
  input  logic [15:0]            screen_width,
  input  logic [15:0]            screen_height,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     target_x,
  output logic signed [31:0]     target_y,
  output logic [22:0]            offset_x,
  output logic [22:0]            offset_y,
  output logic                   moved
);
  import camsf_pkg::*;

  logic [23:0] min_len;
  logic [15:0] gain;
  logic [23:0] min_spd;

  logic signed [31:0] px, py, tx, ty;
  logic [15:0] ft, sw, sh;
  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic [64:0] sqx, sqy;
  logic [65:0] rad;
  logic [33:0] srem;
  logic [32:0] root;
  logic above;
  logic [48:0] gprod;
  logic [40:0] speed;
  logic [56:0] factor;
  logic [61:0] plo;
  logic [60:0] phi;
  logic [48:0] drem;
  logic [43:0] dq;

  logic [32:0] ad_sel;
  logic neg_sel;
  logic signed [31:0] t_sel;

  logic [35:0] rt_sh, rt_trial, rt_diff;
  logic rt_ge;
  logic [49:0] dv_sh, dv_div, dv_diff;
  logic dv_ge;
  logic [89:0] numsum;
  logic [33:0] qs;
  logic signed [35:0] nt;
  logic signed [31:0] t_next;
  logic [40:0] gspeed;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= RST_MIN_EFFECT_LENGTH;
      gain    <= RST_FRACTION_GAIN;
      min_spd <= RST_MIN_SPEED;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_EFFECT_LENGTH: min_len <= cfg_data;
        CFG_FRACTION_GAIN:     gain    <= cfg_data[15:0];
        CFG_MIN_SPEED:         min_spd <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ad_sel  = cmd.axis ? ady : adx;
    neg_sel = cmd.axis ? dy[32] : dx[32];
    t_sel   = cmd.axis ? ty : tx;

    rt_sh    = {srem, rad[65:64]};
    rt_trial = {1'b0, root, 2'b01};
    rt_diff  = rt_sh - rt_trial;
    rt_ge    = rt_sh >= rt_trial;

    dv_sh   = {drem, dq[43]};
    dv_div  = {1'b0, root, 16'b0};
    dv_diff = dv_sh - dv_div;
    dv_ge   = dv_sh >= dv_div;

    numsum = {phi, 29'b0} + {28'b0, plo};
    gspeed = gprod[48:8];

    qs = (dq > {10'b0, STEP_MAX}) ? STEP_MAX : dq[33:0];
    if (neg_sel) begin
      nt = {{4{t_sel[31]}}, t_sel} - $signed({2'b0, qs});
    end else begin
      nt = {{4{t_sel[31]}}, t_sel} + $signed({2'b0, qs});
    end
    if (nt > 36'sd2147483647) begin
      t_next = 32'sh7fff_ffff;
    end else if (nt < -36'sd2147483648) begin
      t_next = 32'sh8000_0000;
    end else begin
      t_next = nt[31:0];
    end
  end

  // camera target
  always_ff @(posedge clk) begin
    if (rst) begin
      tx <= '0;
      ty <= '0;
    end else if (cmd.update && above) begin
      if (cmd.axis) begin
        ty <= t_next;
      end else begin
        tx <= t_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pos_x;
      py <= pos_y;
      ft <= frame_time;
      sw <= screen_width;
      sh <= screen_height;
    end
    if (cmd.diff) begin
      dx <= {px[31], px} - {tx[31], tx};
      dy <= {py[31], py} - {ty[31], ty};
    end
    if (cmd.absval) begin
      adx <= dx[32] ? (~dx + 33'd1) : dx;
      ady <= dy[32] ? (~dy + 33'd1) : dy;
    end
    if (cmd.square) begin
      sqx <= {32'b0, adx} * {32'b0, adx};
      sqy <= {32'b0, ady} * {32'b0, ady};
    end
    if (cmd.sum) begin
      rad  <= {1'b0, sqx} + {1'b0, sqy};
      srem <= '0;
      root <= '0;
    end
    if (cmd.root_step) begin
      rad  <= {rad[63:0], 2'b00};
      srem <= rt_ge ? rt_diff[33:0] : rt_sh[33:0];
      root <= {root[31:0], rt_ge};
    end
    if (cmd.compare) begin
      above <= root > {9'b0, min_len};
    end
    if (cmd.speed_mul) begin
      gprod <= {33'b0, gain} * {16'b0, root};
    end
    if (cmd.speed_max) begin
      speed <= (gspeed > {17'b0, min_spd}) ? gspeed : {17'b0, min_spd};
    end
    if (cmd.factor) begin
      factor <= {16'b0, speed} * {41'b0, ft};
    end
    if (cmd.mul_lo) begin
      plo <= {29'b0, ad_sel} * {33'b0, factor[28:0]};
    end
    if (cmd.mul_hi) begin
      phi <= {28'b0, ad_sel} * {33'b0, factor[56:29]};
    end
    if (cmd.num) begin
      drem <= {3'b0, numsum[89:44]};
      dq   <= numsum[43:0];
    end
    if (cmd.div_step) begin
      drem <= dv_ge ? dv_diff[48:0] : dv_sh[48:0];
      dq   <= {dq[42:0], dv_ge};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      target_x <= tx;
      target_y <= ty;
      offset_x <= {sw, 7'b0};
      offset_y <= {sh, 7'b0};
      moved    <= above;
    end
  end

  assign status.above    = above;
  assign status.out_free = !out_valid || out_ready;

endmodule

/* rtl/core/camsf_ctrl.sv */
// ----------------------------------------------------------------------------
// camsf_ctrl
// Sequencer for one camera update: square root, speed, per-axis divide.
// ----------------------------------------------------------------------------
module camsf_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  camsf_pkg::camsf_status_t status,
  output camsf_pkg::camsf_cmd_t    cmd
);
  import camsf_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_DIFF      = 16'h0002,
    S_ABS       = 16'h0004,
    S_SQUARE    = 16'h0008,
    S_SUM       = 16'h0010,
    S_ROOT      = 16'h0020,
    S_COMPARE   = 16'h0040,
    S_SPEED_MUL = 16'h0080,
    S_SPEED_MAX = 16'h0100,
    S_FACTOR    = 16'h0200,
    S_MUL_LO    = 16'h0400,
    S_MUL_HI    = 16'h0800,
    S_NUM       = 16'h1000,
    S_DIV       = 16'h2000,
    S_UPDATE    = 16'h4000,
    S_DONE      = 16'h8000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_ABS;
      end
      S_ABS: begin
        cmd.absval = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        cnt_next   = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = S_SPEED_MUL;
      end
      S_SPEED_MUL: begin
        cmd.speed_mul = 1'b1;
        axis_next     = 1'b0;
        state_next    = status.above ? S_SPEED_MAX : S_DONE;
      end
      S_SPEED_MAX: begin
        cmd.speed_max = 1'b1;
        state_next    = S_FACTOR;
      end
      S_FACTOR: begin
        cmd.factor = 1'b1;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_NUM;
      end
      S_NUM: begin
        cmd.num    = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (axis) begin
          axis_next  = 1'b0;
          state_next = S_DONE;
        end else begin
          axis_next  = 1'b1;
          state_next = S_MUL_LO;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/camera_smooth_follow.sv */
// ----------------------------------------------------------------------------
// camera_smooth_follow
// Rate-limited smooth-follow 2D camera, one update per input word.
//
// Input channel (in_valid/in_ready) carries the followed position, frame time
// and screen size. Output channel (out_valid/out_ready) returns one word per
// input: camera target, half-screen offset and a moved flag. Config channel
// (cfg_valid/cfg_ready, always ready) writes min_effect_length, fraction_gain
// and min_speed by index; other indexes are ignored.
// Each update runs the 33-step square root. When the distance is above the
// threshold it then runs the speed steps and the 44-step restoring divide,
// once per axis on one shared divider; at or below the threshold it skips
// them. One word is in work at a time.
// Reset clears the camera target to zero, loads the config defaults and
// empties the output register. A stalled receiver holds the result in the
// output register; the block takes and computes the next word meanwhile and
// waits only to hand over its result.
// ----------------------------------------------------------------------------
module camera_smooth_follow (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [15:0]        frame_time,
  input  logic [15:0]        screen_width,
  input  logic [15:0]        screen_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] target_x,
  output logic signed [31:0] target_y,
  output logic [22:0]        offset_x,
  output logic [22:0]        offset_y,
  output logic               moved,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import camsf_pkg::*;

  camsf_cmd_t    cmd;
  camsf_status_t status;

  assign cfg_ready = 1'b1;

  camsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  camsf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .frame_time    (frame_time),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .target_x      (target_x),
    .target_y      (target_y),
    .offset_x      (offset_x),
    .offset_y      (offset_y),
    .moved         (moved)
  );

endmodule

/* rtl/core/camsf_checker.sv */
// ----------------------------------------------------------------------------
// camsf_checker
// Port-level checks for the smooth-follow camera, bound to the top level.
// ----------------------------------------------------------------------------
module camsf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] target_x,
  input logic signed [31:0] target_y,
  input logic [22:0]        offset_x,
  input logic [22:0]        offset_y,
  input logic               moved
);

  // target and moved flag of the output word hold while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(target_x) && $stable(target_y)
      && $stable(moved))
    else $error("output word changed while stalled");

  // reset leaves no stale word
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // one word in work at a time, with a minimum working time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken while a word is in work");

  // offsets are whole pixels
  a_offset_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> offset_x[6:0] == 7'd0 && offset_y[6:0] == 7'd0)
    else $error("offset not a whole pixel");

endmodule

bind camera_smooth_follow camsf_checker u_chk (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the smooth-follow camera. Frames go in through a
// queue-fed driver, each accepted frame is run through a bit-exact predictor
// of the camera target, and every output word is checked field by field
// under random stalls on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import camsf_pkg::*;

  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_FRAMES  = 233;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        ft;
    logic [15:0]        sw;
    logic [15:0]        sh;
    bit                 hold;
  } frame_t;

  typedef struct {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic [22:0]        ox;
    logic [22:0]        oy;
    logic               mv;
  } view_t;

  typedef struct {
    logic [1:0]  idx;
    logic [23:0] data;
  } reg_write_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic [15:0]        frame_time = '0;
  logic [15:0]        screen_width = '0;
  logic [15:0]        screen_height = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic [22:0]        offset_x;
  logic [22:0]        offset_y;
  logic               moved;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  camera_smooth_follow dut (.*);

  always #4 clk = ~clk;

  // camera state and registers as the block should hold them
  longint      cam_x = 0;
  longint      cam_y = 0;
  logic [23:0] cfg_min_len = RST_MIN_EFFECT_LENGTH;
  logic [15:0] cfg_gain    = RST_FRACTION_GAIN;
  logic [23:0] cfg_min_spd = RST_MIN_SPEED;

  frame_t     frame_q[$];
  view_t      view_q[$];
  reg_write_t reg_q[$];

  bit     in_fire = 1'b0;
  bit     cfg_fire = 1'b0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     errors = 0;
  int     cycles = 0;
  longint walk_x = 0;
  longint walk_y = 0;

  function automatic longint clamp32(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic logic [33:0] floor_root(logic [65:0] v);
    logic [33:0] r;
    logic [33:0] t;
    logic [67:0] sq;
    int b;
    r = '0;
    for (b = 33; b >= 0; b--) begin
      t = r | (34'd1 << b);
      sq = 68'(t) * 68'(t);
      if (sq <= 68'(v)) r = t;
    end
    return r;
  endfunction

  function automatic longint step_axis(longint tgt, longint d, logic [63:0] factor,
                                       logic [63:0] divisor);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (d < 0) ? 128'(-d) : 128'(d);
    q = (mag * 128'(factor)) / 128'(divisor);
    if (q > 128'(STEP_MAX)) q = 128'(STEP_MAX);
    return clamp32((d < 0) ? tgt - longint'(q[63:0]) : tgt + longint'(q[63:0]));
  endfunction

  function automatic view_t follow_frame(frame_t f);
    longint      dx;
    longint      dy;
    logic [65:0] ax;
    logic [65:0] ay;
    logic [33:0] len;
    logic [63:0] speed;
    logic [63:0] factor;
    logic [63:0] divisor;
    view_t       v;
    dx = longint'(f.px) - cam_x;
    dy = longint'(f.py) - cam_y;
    ax = (dx < 0) ? 66'(-dx) : 66'(dx);
    ay = (dy < 0) ? 66'(-dy) : 66'(dy);
    len = floor_root(ax * ax + ay * ay);
    v.mv = 1'b0;
    if (len > 34'(cfg_min_len)) begin
      speed = (64'(cfg_gain) * 64'(len)) >> 8;
      if (speed < 64'(cfg_min_spd)) speed = 64'(cfg_min_spd);
      factor = speed * 64'(f.ft);
      divisor = 64'(len) << 16;
      cam_x = step_axis(cam_x, dx, factor, divisor);
      cam_y = step_axis(cam_y, dy, factor, divisor);
      v.mv = 1'b1;
    end
    v.tx = cam_x[31:0];
    v.ty = cam_y[31:0];
    v.ox = {f.sw, 7'd0};
    v.oy = {f.sh, 7'd0};
    return v;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // monitor and prediction
  always @(posedge clk) begin
    view_t  want;
    frame_t f;
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
    in_fire <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (view_q.size() == 0) begin
          $error("word with none expected: target_x %0d, target_y %0d",
                 target_x, target_y);
          errors++;
        end else begin
          want = view_q.pop_front();
          check_field("target_x", want.tx, target_x);
          check_field("target_y", want.ty, target_y);
          check_field("offset_x", want.ox, offset_x);
          check_field("offset_y", want.oy, offset_y);
          check_field("moved", want.mv, moved);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_EFFECT_LENGTH: cfg_min_len = cfg_data;
          CFG_FRACTION_GAIN:     cfg_gain = cfg_data[15:0];
          CFG_MIN_SPEED:         cfg_min_spd = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        f.px = pos_x;
        f.py = pos_y;
        f.ft = frame_time;
        f.sw = screen_width;
        f.sh = screen_height;
        f.hold = 1'b0;
        view_q.push_back(follow_frame(f));
      end
    end
  end

  // driver
  always @(negedge clk) begin
    bit         busy;
    bit         go;
    frame_t     f;
    reg_write_t w;
    busy = in_valid && !in_fire;
    go = busy;
    if (!busy && frame_q.size() != 0 && !(frame_q[0].hold && view_q.size() != 0) &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      f = frame_q.pop_front();
      pos_x <= f.px;
      pos_y <= f.py;
      frame_time <= f.ft;
      screen_width <= f.sw;
      screen_height <= f.sh;
      go = 1'b1;
    end
    in_valid <= go;
    busy = cfg_valid && !cfg_fire;
    go = busy;
    if (!busy && reg_q.size() != 0) begin
      w = reg_q.pop_front();
      cfg_index <= w.idx;
      cfg_data <= w.data;
      go = 1'b1;
    end
    cfg_valid <= go;
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic add_frame(longint x, longint y, int ft, int sw, int sh, bit hold);
    frame_t f;
    f.px = x[31:0];
    f.py = y[31:0];
    f.ft = ft[15:0];
    f.sw = sw[15:0];
    f.sh = sh[15:0];
    f.hold = hold;
    frame_q.push_back(f);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_q.push_back(w);
  endtask

  task automatic settle();
    while (frame_q.size() != 0 || in_valid || view_q.size() != 0 ||
           reg_q.size() != 0 || cfg_valid)
      @(posedge clk);
  endtask

  function automatic longint wander(longint p);
    int     cls;
    longint step;
    cls = $urandom_range(0, 99);
    if (cls < 45) step = $urandom_range(0, 4096);
    else if (cls < 75) step = $urandom_range(0, 1 << 20);
    else if (cls < 92) step = longint'($urandom) >> $urandom_range(0, 31);
    else if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
    else return longint'(int'($urandom));
    return clamp32($urandom_range(0, 1) ? p + step : p - step);
  endfunction

  function automatic int pick_frame_time();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(200, 4000);
    endcase
  endfunction

  initial begin
    int p;
    int n;
    send_idle_pct = 28;
    recv_idle_pct = 87;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // reset settings: threshold edges, zero step, far jumps
    add_frame(0, 0, 1092, 0, 0, 1'b1);
    add_frame(2560, 0, 1092, 65535, 65535, 1'b0);
    add_frame(1810, 1810, 1092, 640, 480, 1'b0);
    add_frame(0, -2561, 0, 1, 1, 1'b0);
    add_frame(POS_MAX, POS_MAX, 65535, 32768, 16384, 1'b0);
    add_frame(POS_MIN, POS_MIN, 65535, 21845, 43690, 1'b0);
    add_frame(POS_MIN, POS_MAX, 1092, 1920, 1080, 1'b0);
    add_frame(POS_MAX, POS_MIN, 32768, 800, 600, 1'b0);
    add_frame(100000, -100000, 1092, 320, 240, 1'b0);
    settle();

    // fast follow with no dead zone: overshoot and saturation
    write_reg(CFG_MIN_EFFECT_LENGTH, 24'd0);
    write_reg(CFG_FRACTION_GAIN, 24'hFFFFFF);
    write_reg(CFG_MIN_SPEED, 24'hFFFFFF);
    settle();
    add_frame(POS_MAX, POS_MAX, 65535, 65535, 0, 1'b1);
    add_frame(POS_MIN, POS_MIN, 65535, 0, 65535, 1'b0);
    add_frame(POS_MIN, POS_MAX, 65535, 1, 2, 1'b0);
    add_frame(POS_MAX, POS_MIN, 1, 3, 4, 1'b0);
    add_frame(1, 0, 65535, 5, 6, 1'b0);
    add_frame(0, 0, 0, 7, 8, 1'b0);
    settle();

    // widest dead zone, zero speed
    write_reg(CFG_MIN_EFFECT_LENGTH, 24'hFFFFFF);
    write_reg(CFG_FRACTION_GAIN, 24'd0);
    write_reg(CFG_MIN_SPEED, 24'd0);
    settle();
    add_frame(0, 0, 65535, 100, 100, 1'b1);
    add_frame(POS_MAX, POS_MAX, 65535, 200, 200, 1'b0);
    add_frame(POS_MIN, 0, 65535, 300, 300, 1'b0);

    for (p = 0; p < 6; p++) begin
      settle();
      case (p / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0: begin
          write_reg(CFG_MIN_EFFECT_LENGTH, 24'($urandom_range(0, 8192)));
          write_reg(CFG_FRACTION_GAIN, 24'($urandom_range(0, 65535)));
          write_reg(CFG_MIN_SPEED, 24'($urandom_range(0, 1 << 16)));
        end
        1: begin
          write_reg(CFG_MIN_EFFECT_LENGTH, 24'd0);
          write_reg(CFG_FRACTION_GAIN, 24'd0);
          write_reg(CFG_MIN_SPEED, 24'd0);
        end
        2: begin
          write_reg(CFG_MIN_EFFECT_LENGTH, 24'hFFFFFF);
          write_reg(CFG_FRACTION_GAIN, 24'hFFFFFF);
          write_reg(CFG_MIN_SPEED, 24'hFFFFFF);
        end
        3: begin
          write_reg(CFG_MIN_EFFECT_LENGTH, 24'd0);
          write_reg(CFG_FRACTION_GAIN, 24'h00FFFF);
          write_reg(CFG_MIN_SPEED, 24'd0);
        end
        4: begin
          write_reg(CFG_MIN_EFFECT_LENGTH, RST_MIN_EFFECT_LENGTH);
          write_reg(CFG_FRACTION_GAIN, 24'(RST_FRACTION_GAIN));
          write_reg(CFG_MIN_SPEED, RST_MIN_SPEED);
          write_reg(CFG_UNUSED, 24'($urandom));
        end
        default: begin
          write_reg(CFG_MIN_EFFECT_LENGTH, 24'($urandom));
          write_reg(CFG_FRACTION_GAIN, 24'($urandom));
          write_reg(CFG_MIN_SPEED, 24'($urandom));
          write_reg(CFG_UNUSED, 24'hFFFFFF);
        end
      endcase
      settle();
      for (n = 0; n < PHASE_FRAMES; n++) begin
        walk_x = wander(walk_x);
        walk_y = wander(walk_y);
        add_frame(walk_x, walk_y, pick_frame_time(), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), n == 0 || $urandom_range(0, 63) == 0);
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
